>>> src/plof_pkg.sv
// Package for the price level order FIFO.
// Holds the payload structs, the operation and status codes and the field widths.
// No dependencies.
package plof_pkg;

  localparam int unsigned DEPTH_DEF   = 64;
  localparam int unsigned ID_BITS     = 32;
  localparam int unsigned QTY_BITS    = 32;
  localparam int unsigned COUNT_BITS  = 7;
  localparam int unsigned TOTAL_BITS  = 38;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_REDUCE = 2'd2,
    OP_FIND   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_BAD_QTY   = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef struct packed {
    op_e                 operation;
    logic [ID_BITS-1:0]  order_id;
    logic [QTY_BITS-1:0] quantity;
  } in_t;

  typedef struct packed {
    status_e               status;
    logic [QTY_BITS-1:0]   found_quantity;
    logic                  head_valid;
    logic [ID_BITS-1:0]    head_id;
    logic [QTY_BITS-1:0]   head_quantity;
    logic [COUNT_BITS-1:0] order_count;
    logic [TOTAL_BITS-1:0] level_total;
  } out_t;

endpackage

>>> src/price_level_order_fifo.sv
// Price level order FIFO: resting orders of one price level kept in arrival order.
// The order pool and its links live in synchronous memories inside this module.
// Depends on plof_pkg.
//
// Usage: each input transaction on in_valid_i/in_stall_o carries one operation
// (add at tail, cancel by id, reduce quantity, find by id) with an id and a
// quantity. Every operation produces exactly one result transaction on
// out_valid_o/out_stall_i with a status, the found quantity, the head order,
// the order count and the level total after the operation.
// Sequence: the id search sweeps the pool one slot per cycle over the single
// read port of the entry memories; the same sweep also picks the lowest free
// slot for an add. After the sweep S_EXEC updates the entry, then S_LINK
// writes the second link of an add to a non-empty level or S_HEADRD reloads
// the head after the head is canceled, and S_DONE loads the result register.
// One operation is in flight at a time; in_stall_o is low only while the block
// is idle, so a new operation is accepted only after the last result is loaded.
// Reset empties the level at once: valid bits, count, total, head and tail
// clear; the entry memories need no clearing. A stalled result waits in the
// output register and holds; the next operation may be accepted meanwhile but
// its result is not loaded until the waiting one has been taken.
module price_level_order_fifo #(
  parameter int unsigned DEPTH = plof_pkg::DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  plof_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output plof_pkg::out_t out_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW = AW + 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned TW = plof_pkg::QTY_BITS + AW;
  localparam logic [SW-1:0] SCAN_END = SW'(DEPTH);

  localparam int unsigned IB = plof_pkg::ID_BITS;
  localparam int unsigned QB = plof_pkg::QTY_BITS;

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_EXEC   = 6'b000100,
    S_LINK   = 6'b001000,
    S_HEADRD = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  // Entry memories.
  logic [IB-1:0] id_mem   [DEPTH];
  logic [QB-1:0] qty_mem  [DEPTH];
  logic [AW-1:0] prev_mem [DEPTH];
  logic [AW-1:0] next_mem [DEPTH];

  state_e           state_q;
  plof_pkg::in_t    req_q;
  logic [DEPTH-1:0] valid_q;
  logic [AW-1:0]    head_q, tail_q, lnk_q;
  logic [CW-1:0]    count_q;
  logic [TW-1:0]    total_q;
  logic [IB-1:0]    head_id_q;
  logic [QB-1:0]    head_qty_q;

  // Sweep state: the read issued last cycle is compared this cycle.
  logic [SW-1:0]    cnt_q;
  logic             cmp_v_q;
  logic [AW-1:0]    cmp_idx_q;
  logic             hit_q, free_ok_q;
  logic [AW-1:0]    hit_slot_q, free_slot_q, hit_prev_q, hit_next_q;
  logic [QB-1:0]    hit_qty_q;

  // Registered read data.
  logic [IB-1:0]    id_rd_q;
  logic [QB-1:0]    qty_rd_q;
  logic [AW-1:0]    prev_rd_q, next_rd_q;

  plof_pkg::status_e res_status_q;
  logic [QB-1:0]     res_found_q;
  logic              out_valid_q;
  plof_pkg::out_t    out_q;

  // Memory port strobes.
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          id_we, qty_we, prev_we, next_we;
  logic [AW-1:0] ent_wa, prev_wa, next_wa;
  logic [QB-1:0] qty_wd;
  logic [AW-1:0] prev_wd, next_wd;

  // Operation decode after the sweep.
  plof_pkg::status_e status_c;
  logic [QB-1:0]     found_c;
  logic              add_ok, cancel_ok, reduce_ok, has_prev, has_next;
  logic              in_fire, out_load;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign has_prev = (hit_slot_q != head_q);
  assign has_next = (hit_slot_q != tail_q);

  always_comb begin
    status_c  = plof_pkg::ST_OK;
    found_c   = '0;
    add_ok    = 1'b0;
    cancel_ok = 1'b0;
    reduce_ok = 1'b0;
    if (req_q.operation == plof_pkg::OP_ADD) begin
      if (hit_q) begin
        status_c = plof_pkg::ST_DUPLICATE;
      end else if (req_q.quantity == '0) begin
        status_c = plof_pkg::ST_BAD_QTY;
      end else if (!free_ok_q) begin
        status_c = plof_pkg::ST_FULL;
      end else begin
        add_ok = 1'b1;
      end
    end else if (!hit_q) begin
      status_c = plof_pkg::ST_NOT_FOUND;
    end else begin
      case (req_q.operation)
        plof_pkg::OP_CANCEL: begin
          cancel_ok = 1'b1;
        end
        plof_pkg::OP_REDUCE: begin
          if (req_q.quantity == '0 || req_q.quantity > hit_qty_q) begin
            status_c = plof_pkg::ST_BAD_QTY;
          end else begin
            reduce_ok = 1'b1;
          end
        end
        default: begin
          found_c = hit_qty_q;
        end
      endcase
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    id_we   = 1'b0;
    qty_we  = 1'b0;
    prev_we = 1'b0;
    next_we = 1'b0;
    ent_wa  = free_slot_q;
    prev_wa = '0;
    next_wa = '0;
    qty_wd  = req_q.quantity;
    prev_wd = '0;
    next_wd = '0;
    case (state_q)
      S_SCAN: begin
        rd_en   = (cnt_q != SCAN_END);
        rd_addr = cnt_q[AW-1:0];
      end
      S_EXEC: begin
        if (add_ok) begin
          id_we   = 1'b1;
          qty_we  = 1'b1;
          prev_we = 1'b1;
          prev_wa = free_slot_q;
          prev_wd = tail_q;
          next_we = 1'b1;
          next_wa = free_slot_q;
          next_wd = free_slot_q;
        end else if (cancel_ok) begin
          next_we = has_prev;
          next_wa = hit_prev_q;
          next_wd = hit_next_q;
          prev_we = has_next;
          prev_wa = hit_next_q;
          prev_wd = hit_prev_q;
          // The new head's id and quantity are fetched when the head leaves.
          rd_en   = !has_prev;
          rd_addr = hit_next_q;
        end else if (reduce_ok) begin
          qty_we = 1'b1;
          ent_wa = hit_slot_q;
        end
      end
      S_LINK: begin
        next_we = 1'b1;
        next_wa = lnk_q;
        next_wd = tail_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (id_we) begin
      id_mem[ent_wa] <= req_q.order_id;
    end
    if (qty_we) begin
      qty_mem[ent_wa] <= qty_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (rd_en) begin
      id_rd_q   <= id_mem[rd_addr];
      qty_rd_q  <= qty_mem[rd_addr];
      prev_rd_q <= prev_mem[rd_addr];
      next_rd_q <= next_mem[rd_addr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_data_i;
    end
    cmp_idx_q <= rd_addr;
    if (state_q == S_SCAN && cmp_v_q) begin
      if (valid_q[cmp_idx_q] && id_rd_q == req_q.order_id && !hit_q) begin
        hit_slot_q <= cmp_idx_q;
        hit_qty_q  <= qty_rd_q;
        hit_prev_q <= prev_rd_q;
        hit_next_q <= next_rd_q;
      end
      if (!valid_q[cmp_idx_q] && !free_ok_q) begin
        free_slot_q <= cmp_idx_q;
      end
    end
    if (state_q == S_EXEC) begin
      res_status_q <= status_c;
      res_found_q  <= found_c;
      lnk_q        <= tail_q;
    end
    if (out_load) begin
      out_q.status         <= res_status_q;
      out_q.found_quantity <= res_found_q;
      out_q.head_valid     <= (count_q != '0);
      out_q.head_id        <= (count_q != '0) ? head_id_q : '0;
      out_q.head_quantity  <= (count_q != '0) ? head_qty_q : '0;
      out_q.order_count    <= plof_pkg::COUNT_BITS'(count_q);
      out_q.level_total    <= plof_pkg::TOTAL_BITS'(total_q);
    end
  end

  // Control and level state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      total_q     <= '0;
      head_id_q   <= '0;
      head_qty_q  <= '0;
      cnt_q       <= '0;
      cmp_v_q     <= 1'b0;
      hit_q       <= 1'b0;
      free_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          cnt_q     <= '0;
          cmp_v_q   <= 1'b0;
          hit_q     <= 1'b0;
          free_ok_q <= 1'b0;
          if (in_fire) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_v_q <= rd_en;
          if (rd_en) begin
            cnt_q <= cnt_q + SW'(1);
          end
          if (cmp_v_q) begin
            if (valid_q[cmp_idx_q] && id_rd_q == req_q.order_id) begin
              hit_q <= 1'b1;
            end
            if (!valid_q[cmp_idx_q]) begin
              free_ok_q <= 1'b1;
            end
          end
          if (!rd_en && cmp_v_q) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_DONE;
          if (add_ok) begin
            valid_q[free_slot_q] <= 1'b1;
            tail_q  <= free_slot_q;
            count_q <= count_q + CW'(1);
            total_q <= total_q + TW'(req_q.quantity);
            if (count_q == '0) begin
              head_q     <= free_slot_q;
              head_id_q  <= req_q.order_id;
              head_qty_q <= req_q.quantity;
            end else begin
              state_q <= S_LINK;
            end
          end else if (cancel_ok) begin
            valid_q[hit_slot_q] <= 1'b0;
            count_q <= count_q - CW'(1);
            total_q <= total_q - TW'(hit_qty_q);
            if (!has_prev) begin
              head_q  <= hit_next_q;
              state_q <= S_HEADRD;
            end
            if (!has_next) begin
              tail_q <= hit_prev_q;
            end
          end else if (reduce_ok) begin
            total_q <= total_q - TW'(hit_qty_q - req_q.quantity);
            if (hit_slot_q == head_q) begin
              head_qty_q <= req_q.quantity;
            end
          end
        end
        S_LINK: begin
          state_q <= S_DONE;
        end
        S_HEADRD: begin
          head_id_q  <= id_rd_q;
          head_qty_q <= qty_rd_q;
          state_q    <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The count always matches the number of occupied slots.
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == count_q)
    else $error("order count differs from occupied slots");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("order count above pool depth");

  a_head_valid_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.head_valid == (out_q.order_count != '0)))
    else $error("head valid disagrees with order count");

  a_no_result_right_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !out_load)
    else $error("result loaded before the sweep ran");

endmodule
